@@ src/fm_stereo_tone_synth_defines.svh @@
// assertion macros for the tone synth top module
`ifndef FM_STEREO_TONE_SYNTH_DEFINES_SVH
`define FM_STEREO_TONE_SYNTH_DEFINES_SVH

// same-cycle implication, held off during reset
`define FMST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off during reset
`define FMST_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/fmst_pkg.sv @@
`timescale 1ns / 1ps

package fmst_pkg;

	localparam int PHASE_BITS_DEF  = 32;
	localparam int TABLE_BITS_DEF  = 10;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int STEP_BITS      = 32;
	localparam int AMP_BITS       = 15;
	localparam int INDEX_BITS     = 40;
	localparam int HALF_BITS      = INDEX_BITS / 2;
	localparam int CFG_DATA_BITS  = 40;
	localparam int CFG_INDEX_BITS = 3;
	localparam int ROUND_HALF     = 1 << (AMP_BITS - 1);

	localparam logic [STEP_BITS-1:0]  CARRIER_STEP_RST   = 32'd77913239;
	localparam logic [STEP_BITS-1:0]  DETUNE_STEP_RST    = 32'd194783;
	localparam logic [STEP_BITS-1:0]  MOD_STEP_RST       = 32'd3895662;
	localparam logic [AMP_BITS-1:0]   AMPLITUDE_RST      = 15'd32767;
	localparam logic [STEP_BITS-1:0]  CARRIER_OFFSET_RST = 32'd0;
	localparam logic [STEP_BITS-1:0]  MOD_OFFSET_RST     = 32'd0;
	localparam logic [STEP_BITS-1:0]  INDEX_STEP_RST     = 32'd31001;
	localparam logic [INDEX_BITS-1:0] INDEX_LIMIT_RST    = 40'd6835652747;

	// pi/2 in Q30
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_CARRIER_STEP   = 3'd0,
		REG_DETUNE_STEP    = 3'd1,
		REG_MOD_STEP       = 3'd2,
		REG_AMPLITUDE      = 3'd3,
		REG_CARRIER_OFFSET = 3'd4,
		REG_MOD_OFFSET     = 3'd5,
		REG_INDEX_STEP     = 3'd6,
		REG_INDEX_LIMIT    = 3'd7
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MOD_RD,
		S_MOD_SCALE,
		S_DEV_LO,
		S_DEV_HI,
		S_BASE,
		S_LEFT_RD,
		S_LEFT_SCALE,
		S_RIGHT_RD,
		S_RIGHT_SCALE,
		S_FINISH
	} state_t;

	// quarter-wave entry k, Q30 taylor series to x^13, evaluated at elaboration
	function automatic logic [31:0] sine_entry(input int k, input int table_bits,
		input int sample_bits);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic [63:0]        fs;
		logic [63:0]        v;
		logic signed [63:0] sum;
		x    = (HALF_PI_Q30 * (64'(2 * k) + 64'd1)) >> (table_bits + 1);
		x2   = (x * x) >> 30;
		fs   = (64'd1 << (sample_bits - 1)) - 64'd1;
		term = x;
		sum  = signed'(x);
		term = ((term * x2) >> 30) / 64'd6;
		sum  = sum - signed'(term);
		term = ((term * x2) >> 30) / 64'd20;
		sum  = sum + signed'(term);
		term = ((term * x2) >> 30) / 64'd42;
		sum  = sum - signed'(term);
		term = ((term * x2) >> 30) / 64'd72;
		sum  = sum + signed'(term);
		term = ((term * x2) >> 30) / 64'd110;
		sum  = sum - signed'(term);
		term = ((term * x2) >> 30) / 64'd156;
		sum  = sum + signed'(term);
		if (sum < 0) begin
			sum = '0;
		end
		v = ((unsigned'(sum) * fs) + (64'd1 << 29)) >> 30;
		if (v > fs) begin
			v = fs;
		end
		return 32'(v);
	endfunction

endpackage

@@ src/fmst_in_if.sv @@
`timescale 1ns / 1ps

interface fmst_in_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

@@ src/fmst_out_if.sv @@
`timescale 1ns / 1ps

interface fmst_out_if #(
	parameter int SAMPLE_BITS = fmst_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_sample;
	logic signed [SAMPLE_BITS-1:0] right_sample;
	logic                          ramp_done;

	modport source (output valid, output left_sample, output right_sample,
		output ramp_done, input ready);
	modport sink (input valid, input left_sample, input right_sample,
		input ramp_done, output ready);
endinterface

@@ src/fmst_sine_rom.sv @@
`timescale 1ns / 1ps

module fmst_sine_rom #(
	parameter int PHASE_BITS  = fmst_pkg::PHASE_BITS_DEF,
	parameter int TABLE_BITS  = fmst_pkg::TABLE_BITS_DEF,
	parameter int SAMPLE_BITS = fmst_pkg::SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic [PHASE_BITS-1:0]  phase,
	output logic [SAMPLE_BITS-2:0] mag,
	output logic                   neg
);

	localparam int DEPTH    = 1 << TABLE_BITS;
	localparam int MAG_BITS = SAMPLE_BITS - 1;

	typedef logic [MAG_BITS-1:0] rom_array_t [DEPTH];

	function automatic rom_array_t build_rom();
		rom_array_t r;
		for (int k = 0; k < DEPTH; k++) begin
			r[k] = MAG_BITS'(fmst_pkg::sine_entry(k, TABLE_BITS, SAMPLE_BITS));
		end
		return r;
	endfunction

	localparam rom_array_t ROM = build_rom();

	logic [1:0]            quad;
	logic [TABLE_BITS-1:0] entry;
	logic [TABLE_BITS-1:0] addr;
	logic [MAG_BITS-1:0]   mag_q;
	logic                  neg_q;

	assign quad  = phase[PHASE_BITS-1 -: 2];
	assign entry = phase[PHASE_BITS-3 -: TABLE_BITS];
	// odd quadrants run the table backwards
	assign addr  = quad[0] ? ~entry : entry;

	always_ff @(posedge clk) begin
		mag_q <= ROM[addr];
		neg_q <= quad[1];
	end

	assign mag = mag_q;
	assign neg = neg_q;

endmodule

@@ src/fmst_mul.sv @@
`timescale 1ns / 1ps

module fmst_mul #(
	parameter int A_BITS = fmst_pkg::SAMPLE_BITS_DEF - 1,
	parameter int B_BITS = fmst_pkg::HALF_BITS
) (
	input  logic [A_BITS-1:0]        a,
	input  logic [B_BITS-1:0]        b,
	output logic [A_BITS+B_BITS-1:0] p
);

	assign p = (A_BITS + B_BITS)'(a) * (A_BITS + B_BITS)'(b);

endmodule

@@ src/fm_stereo_tone_synth.sv @@
`timescale 1ns / 1ps
// channel  role    payload                               handshake
// tick     sink    restart                               valid / ready
// frame    source  left_sample, right_sample, ramp_done  valid / ready
// cfg      write   cfg_index, cfg_data                   cfg_wen, no wait
//
// a tick is taken only in idle, after the previous frame's finishing step;
// ten sequencer steps share one multiplier (five uses) and one sine rom read port
// the frame becomes valid when the finishing step loads the output register
// arst_n clears sequencer, accumulators, output valid; config regs get defaults
// one finished frame waits in the output register while the next tick is worked;
// the finishing step holds until that register is free

`include "fm_stereo_tone_synth_defines.svh"

module fm_stereo_tone_synth #(
	parameter int PHASE_BITS  = fmst_pkg::PHASE_BITS_DEF,
	parameter int TABLE_BITS  = fmst_pkg::TABLE_BITS_DEF,
	parameter int SAMPLE_BITS = fmst_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	fmst_in_if.sink                             tick,
	fmst_out_if.source                          frame,
	input  logic                                cfg_wen,
	input  logic [fmst_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [fmst_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int STEP_BITS  = fmst_pkg::STEP_BITS;
	localparam int AMP_BITS   = fmst_pkg::AMP_BITS;
	localparam int IB         = fmst_pkg::INDEX_BITS;
	localparam int HB         = fmst_pkg::HALF_BITS;
	localparam int MAG_BITS   = SAMPLE_BITS - 1;
	localparam int MUL_BITS   = MAG_BITS + HB;
	localparam int PROD_BITS  = IB + MAG_BITS;
	localparam int DEV_SHIFT  = 31 + SAMPLE_BITS - PHASE_BITS;
	localparam int RSH        = (DEV_SHIFT > 0) ? DEV_SHIFT : 0;
	localparam int LSH        = (DEV_SHIFT < 0) ? -DEV_SHIFT : 0;

	logic [STEP_BITS-1:0]  carrier_step_q;
	logic [STEP_BITS-1:0]  detune_step_q;
	logic [STEP_BITS-1:0]  mod_step_q;
	logic [AMP_BITS-1:0]   amplitude_q;
	logic [STEP_BITS-1:0]  carrier_offset_q;
	logic [STEP_BITS-1:0]  mod_offset_q;
	logic [STEP_BITS-1:0]  index_step_q;
	logic [IB-1:0]         index_limit_q;

	logic [PHASE_BITS-1:0] left_phase_q;
	logic [PHASE_BITS-1:0] right_phase_q;
	logic [PHASE_BITS-1:0] mod_phase_q;
	logic [IB-1:0]         index_acc_q;

	logic [IB-1:0]                 idx_q;
	logic                          done_q;
	logic [MAG_BITS-1:0]           m_mag_q;
	logic                          m_neg_q;
	logic [PROD_BITS-1:0]          prod_q;
	logic [PHASE_BITS-1:0]         base_q;
	logic signed [SAMPLE_BITS-1:0] left_q;
	logic signed [SAMPLE_BITS-1:0] right_q;

	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_left_q;
	logic signed [SAMPLE_BITS-1:0] out_right_q;
	logic                          out_done_q;

	fmst_pkg::state_t state_q;
	fmst_pkg::state_t state_d;

	logic [PHASE_BITS-1:0] rom_base;
	logic [PHASE_BITS-1:0] rom_add;
	logic [PHASE_BITS-1:0] rom_phase;
	logic [MAG_BITS-1:0]   rom_mag;
	logic                  rom_neg;
	logic [MAG_BITS-1:0]   mul_a;
	logic [HB-1:0]         mul_b;
	logic [MUL_BITS-1:0]   mul_p;
	logic [MUL_BITS:0]     round_sum;
	logic [MAG_BITS-1:0]   scaled;
	logic [SAMPLE_BITS-1:0] sample_val;
	logic [PHASE_BITS-1:0] dev_mag;
	logic [PHASE_BITS-1:0] signed_dev;
	logic [IB:0]           next_index;
	logic                  tick_take;
	logic                  out_free;
	logic                  out_load;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carrier_step_q   <= fmst_pkg::CARRIER_STEP_RST;
			detune_step_q    <= fmst_pkg::DETUNE_STEP_RST;
			mod_step_q       <= fmst_pkg::MOD_STEP_RST;
			amplitude_q      <= fmst_pkg::AMPLITUDE_RST;
			carrier_offset_q <= fmst_pkg::CARRIER_OFFSET_RST;
			mod_offset_q     <= fmst_pkg::MOD_OFFSET_RST;
			index_step_q     <= fmst_pkg::INDEX_STEP_RST;
			index_limit_q    <= fmst_pkg::INDEX_LIMIT_RST;
		end else if (cfg_wen) begin
			unique case (fmst_pkg::cfg_reg_t'(cfg_index))
				fmst_pkg::REG_CARRIER_STEP:   carrier_step_q   <= cfg_data[STEP_BITS-1:0];
				fmst_pkg::REG_DETUNE_STEP:    detune_step_q    <= cfg_data[STEP_BITS-1:0];
				fmst_pkg::REG_MOD_STEP:       mod_step_q       <= cfg_data[STEP_BITS-1:0];
				fmst_pkg::REG_AMPLITUDE:      amplitude_q      <= cfg_data[AMP_BITS-1:0];
				fmst_pkg::REG_CARRIER_OFFSET: carrier_offset_q <= cfg_data[STEP_BITS-1:0];
				fmst_pkg::REG_MOD_OFFSET:     mod_offset_q     <= cfg_data[STEP_BITS-1:0];
				fmst_pkg::REG_INDEX_STEP:     index_step_q     <= cfg_data[STEP_BITS-1:0];
				fmst_pkg::REG_INDEX_LIMIT:    index_limit_q    <= cfg_data[IB-1:0];
			endcase
		end
	end

	fmst_sine_rom #(
		.PHASE_BITS  (PHASE_BITS),
		.TABLE_BITS  (TABLE_BITS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_rom (
		.clk   (clk),
		.phase (rom_phase),
		.mag   (rom_mag),
		.neg   (rom_neg)
	);

	fmst_mul #(
		.A_BITS (MAG_BITS),
		.B_BITS (HB)
	) u_mul (
		.a (mul_a),
		.b (mul_b),
		.p (mul_p)
	);

	assign out_free  = !out_valid_q || frame.ready;
	assign tick_take = tick.valid && tick.ready;
	assign out_load  = (state_q == fmst_pkg::S_FINISH) && out_free;

	// amplitude scaling, halves rounded away from zero on the magnitude
	assign round_sum = {1'b0, mul_p} + (MUL_BITS + 1)'(fmst_pkg::ROUND_HALF);
	assign scaled    = MAG_BITS'(round_sum >> AMP_BITS);
	// magnitude never exceeds full scale, so the clamp is a plain sign apply
	assign sample_val = rom_neg ? (SAMPLE_BITS'(0) - SAMPLE_BITS'(scaled))
		: SAMPLE_BITS'(scaled);

	assign dev_mag    = PHASE_BITS'(prod_q >> RSH) << LSH;
	assign signed_dev = m_neg_q ? (PHASE_BITS'(0) - dev_mag) : dev_mag;
	assign rom_phase  = rom_base + rom_add;
	assign next_index = {1'b0, idx_q} + (IB + 1)'(index_step_q);

	// sequencer: next state and operand selection
	always_comb begin
		state_d    = state_q;
		tick.ready = 1'b0;
		rom_base   = mod_phase_q;
		rom_add    = PHASE_BITS'(mod_offset_q);
		mul_a      = rom_mag;
		mul_b      = HB'(amplitude_q);
		unique case (state_q)
			fmst_pkg::S_IDLE: begin
				tick.ready = 1'b1;
				if (tick.valid) begin
					state_d = fmst_pkg::S_MOD_RD;
				end
			end
			fmst_pkg::S_MOD_RD:    state_d = fmst_pkg::S_MOD_SCALE;
			fmst_pkg::S_MOD_SCALE: state_d = fmst_pkg::S_DEV_LO;
			fmst_pkg::S_DEV_LO: begin
				mul_a   = m_mag_q;
				mul_b   = idx_q[HB-1:0];
				state_d = fmst_pkg::S_DEV_HI;
			end
			fmst_pkg::S_DEV_HI: begin
				mul_a   = m_mag_q;
				mul_b   = idx_q[IB-1:HB];
				state_d = fmst_pkg::S_BASE;
			end
			fmst_pkg::S_BASE:      state_d = fmst_pkg::S_LEFT_RD;
			fmst_pkg::S_LEFT_RD: begin
				rom_base = left_phase_q;
				rom_add  = base_q;
				state_d  = fmst_pkg::S_LEFT_SCALE;
			end
			fmst_pkg::S_LEFT_SCALE: state_d = fmst_pkg::S_RIGHT_RD;
			fmst_pkg::S_RIGHT_RD: begin
				rom_base = right_phase_q;
				rom_add  = base_q;
				state_d  = fmst_pkg::S_RIGHT_SCALE;
			end
			fmst_pkg::S_RIGHT_SCALE: state_d = fmst_pkg::S_FINISH;
			fmst_pkg::S_FINISH: begin
				if (out_free) begin
					state_d = fmst_pkg::S_IDLE;
				end
			end
			default: state_d = fmst_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fmst_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_phase_q  <= '0;
			right_phase_q <= '0;
			mod_phase_q   <= '0;
			index_acc_q   <= '0;
		end else begin
			if (tick_take && tick.restart) begin
				left_phase_q  <= '0;
				right_phase_q <= '0;
				mod_phase_q   <= '0;
				index_acc_q   <= '0;
			end
			if (state_q == fmst_pkg::S_MOD_SCALE) begin
				mod_phase_q <= mod_phase_q + PHASE_BITS'(mod_step_q);
			end
			if (state_q == fmst_pkg::S_DEV_LO) begin
				index_acc_q <= (next_index < {1'b0, index_limit_q}) ? IB'(next_index)
					: index_limit_q;
			end
			if (state_q == fmst_pkg::S_LEFT_SCALE) begin
				left_phase_q <= left_phase_q + PHASE_BITS'(carrier_step_q);
			end
			if (state_q == fmst_pkg::S_RIGHT_SCALE) begin
				right_phase_q <= right_phase_q + PHASE_BITS'(carrier_step_q)
					+ PHASE_BITS'(detune_step_q);
			end
		end
	end

	// per-frame working registers
	always_ff @(posedge clk) begin
		case (state_q)
			fmst_pkg::S_MOD_RD: begin
				// index clamps at once if the limit was lowered below it
				idx_q  <= (index_acc_q < index_limit_q) ? index_acc_q : index_limit_q;
				done_q <= !(index_acc_q < index_limit_q);
			end
			fmst_pkg::S_MOD_SCALE: begin
				m_mag_q <= scaled;
				m_neg_q <= rom_neg;
			end
			fmst_pkg::S_DEV_LO: prod_q <= PROD_BITS'(mul_p);
			fmst_pkg::S_DEV_HI: prod_q <= prod_q + (PROD_BITS'(mul_p) << HB);
			fmst_pkg::S_BASE:   base_q <= PHASE_BITS'(carrier_offset_q) + signed_dev;
			fmst_pkg::S_LEFT_SCALE:  left_q  <= sample_val;
			fmst_pkg::S_RIGHT_SCALE: right_q <= sample_val;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (frame.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_left_q  <= left_q;
			out_right_q <= right_q;
			out_done_q  <= done_q;
		end
	end

	assign frame.valid        = out_valid_q;
	assign frame.left_sample  = out_left_q;
	assign frame.right_sample = out_right_q;
	assign frame.ramp_done    = out_done_q;

	`FMST_ASSERT_NXT(a_one_frame_at_a_time, clk, arst_n, tick.valid && tick.ready, !tick.ready, "tick taken while a frame is in work")
	`FMST_ASSERT_IMP(a_index_in_range, clk, arst_n, state_q != fmst_pkg::S_IDLE && state_q != fmst_pkg::S_MOD_RD, idx_q <= index_limit_q, "modulation index above limit")
	`FMST_ASSERT_IMP(a_ramp_bounded, clk, arst_n, state_q == fmst_pkg::S_FINISH, index_acc_q <= index_limit_q, "index ramp ran past limit")
	`FMST_ASSERT_NXT(a_frame_loaded, clk, arst_n, state_q == fmst_pkg::S_FINISH && out_free, frame.valid && state_q == fmst_pkg::S_IDLE, "finished frame not presented")

endmodule
